/* design/wsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types, register codes and CORDIC constants of the wall projector.
// ----------------------------------------------------------------------------
package wsp_pkg;

    typedef struct packed {
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic signed [23:0] floor_z;
        logic signed [23:0] ceiling_span;
    } wall_t;

    typedef struct packed {
        logic signed [15:0] left_column;
        logic signed [15:0] right_column;
        logic signed [15:0] left_floor_row;
        logic signed [15:0] right_floor_row;
        logic signed [15:0] left_ceiling_row;
        logic signed [15:0] right_ceiling_row;
        logic               skip;
        logic signed [15:0] shade;
    } proj_t;

    localparam logic [2:0] CFG_CAMERA_X   = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y   = 3'd1;
    localparam logic [2:0] CFG_YAW_COSINE = 3'd2;
    localparam logic [2:0] CFG_YAW_SINE   = 3'd3;
    localparam logic [2:0] CFG_EYE_HEIGHT = 3'd4;

    localparam logic signed [15:0] YAW_COSINE_RESET = 16'sd16384;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_W      = 22;
    localparam int CORDIC_W     = 48;

    localparam logic signed [ANGLE_W-1:0] TURN_HALF   = 22'sd524288;
    localparam logic signed [16:0]        SHADE_LIMIT = 17'sd16384;

    function automatic logic signed [ANGLE_W-1:0] cordic_angle(input int i);
        logic signed [ANGLE_W-1:0] a;
        case (i)
            0:       a = 22'sd131072;
            1:       a = 22'sd77376;
            2:       a = 22'sd40884;
            3:       a = 22'sd20753;
            4:       a = 22'sd10417;
            5:       a = 22'sd5213;
            6:       a = 22'sd2607;
            7:       a = 22'sd1304;
            8:       a = 22'sd652;
            9:       a = 22'sd326;
            10:      a = 22'sd163;
            11:      a = 22'sd81;
            12:      a = 22'sd41;
            13:      a = 22'sd20;
            14:      a = 22'sd10;
            15:      a = 22'sd5;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/wsp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined signed floor divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module wsp_div #(
    parameter int NW = 51,
    parameter int DW = 42
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    output logic signed [NW+1:0]      quo
);

    logic [NW-1:0] n_reg   [0:NW];
    logic [DW-1:0] d_reg   [0:NW];
    logic [DW-1:0] rem_reg [0:NW];
    logic [NW-1:0] q_reg   [0:NW];
    logic          neg_reg [0:NW];
    logic signed [NW+1:0] quo_reg;
    logic signed [NW+1:0] qe;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= num[NW-1] ? $unsigned(~num + 1'b1) : $unsigned(num);
            d_reg[0]   <= den[DW-1] ? $unsigned(~den + 1'b1) : $unsigned(den);
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
        end
    end

    for (genvar s = 0; s < NW; s++)
    begin : g_stage
        logic [DW:0] trial;
        logic        fits;
        assign trial = {rem_reg[s], n_reg[s][NW-1]};
        assign fits  = trial >= {1'b0, d_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= fits ? DW'(trial - {1'b0, d_reg[s]}) : trial[DW-1:0];
                n_reg[s+1]   <= n_reg[s] << 1;
                q_reg[s+1]   <= {q_reg[s][NW-2:0], fits};
                d_reg[s+1]   <= d_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign qe = $signed({2'b00, q_reg[NW]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[NW])
                quo_reg <= -qe - $signed({{(NW+1){1'b0}}, (rem_reg[NW] != '0)});
            else
                quo_reg <= qe;
        end
    end

    assign quo = quo_reg;

endmodule
`default_nettype wire

/* design/wsp_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_lane
// One endpoint: translate, rotate, then column and row divides.
// ----------------------------------------------------------------------------
module wsp_lane #(
    parameter int PROJECTION_SCALE = 200,
    parameter int NUM_W            = 51
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [23:0]      px,
    input  wire logic signed [23:0]      py,
    input  wire logic signed [23:0]      cam_x,
    input  wire logic signed [23:0]      cam_y,
    input  wire logic signed [15:0]      cosv,
    input  wire logic signed [15:0]      sinv,
    input  wire logic signed [23:0]      fz,
    input  wire logic signed [23:0]      cs,
    input  wire logic signed [23:0]      eye,
    output logic signed [NUM_W+1:0]      col_q,
    output logic signed [NUM_W+1:0]      floor_q,
    output logic signed [NUM_W+1:0]      ceil_q
);

    localparam int PS_W = $clog2(PROJECTION_SCALE + 1);
    localparam logic signed [PS_W:0] PS = (PS_W+1)'(PROJECTION_SCALE);

    logic signed [24:0]        dx_reg, dy_reg, hf_reg;
    logic signed [25:0]        hc_reg;
    logic signed [40:0]        pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [PS_W+25:0]   hfs2_reg, hfs3_reg;
    logic signed [PS_W+26:0]   hcs2_reg, hcs3_reg;
    logic signed [41:0]        rx_reg, ry3_reg, ry4_reg;
    logic signed [41:0]        rx_next, ry_next;
    logic signed [NUM_W-1:0]   ncol_reg, nf_reg, nc_reg;

    assign rx_next = 42'(pa_reg) - 42'(pb_reg);
    assign ry_next = 42'(pc_reg) + 42'(pd_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= 25'(px) - 25'(cam_x);
            dy_reg   <= 25'(py) - 25'(cam_y);
            hf_reg   <= 25'(fz) - 25'(eye);
            hc_reg   <= 26'(fz) + 26'(cs) - 26'(eye);

            pa_reg   <= dx_reg * cosv;
            pb_reg   <= dy_reg * sinv;
            pc_reg   <= dx_reg * sinv;
            pd_reg   <= dy_reg * cosv;
            hfs2_reg <= hf_reg * PS;
            hcs2_reg <= hc_reg * PS;

            rx_reg   <= rx_next;
            ry3_reg  <= (ry_next == '0) ? 42'sd1 : ry_next;
            hfs3_reg <= hfs2_reg;
            hcs3_reg <= hcs2_reg;

            ncol_reg <= rx_reg * PS;
            ry4_reg  <= ry3_reg;
            nf_reg   <= NUM_W'(hfs3_reg) <<< 14;
            nc_reg   <= NUM_W'(hcs3_reg) <<< 14;
        end
    end

    wsp_div #(.NW(NUM_W), .DW(42)) u_div_col (
        .clk (clk), .en (en), .num (ncol_reg), .den (ry4_reg), .quo (col_q)
    );

    wsp_div #(.NW(NUM_W), .DW(42)) u_div_floor (
        .clk (clk), .en (en), .num (nf_reg), .den (ry4_reg), .quo (floor_q)
    );

    wsp_div #(.NW(NUM_W), .DW(42)) u_div_ceil (
        .clk (clk), .en (en), .num (nc_reg), .den (ry4_reg), .quo (ceil_q)
    );

endmodule
`default_nettype wire

/* design/wsp_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_cordic
// Pipelined vectoring CORDIC giving the wall direction in turns.
// ----------------------------------------------------------------------------
module wsp_cordic #(
    parameter int LAT = 57
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [23:0] sx,
    input  wire logic signed [23:0] sy,
    input  wire logic signed [23:0] ex,
    input  wire logic signed [23:0] ey,
    output logic signed [15:0]      shade
);
    import wsp_pkg::*;

    localparam int PAD = LAT - CORDIC_STEPS - 3;

    logic signed [24:0]         ddx_reg, ddy_reg;
    logic signed [CORDIC_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ANGLE_W-1:0]  z_reg [0:CORDIC_STEPS];
    logic                       hz_reg [0:CORDIC_STEPS];
    logic signed [15:0]         hv_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x0, y0;
    logic signed [ANGLE_W-1:0]  zr;
    logic signed [16:0]         q;
    logic signed [15:0]         shade_reg;

    assign x0 = CORDIC_W'(ddx_reg) <<< 20;
    assign y0 = CORDIC_W'(ddy_reg) <<< 20;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ddx_reg <= 25'(ex) - 25'(sx);
            ddy_reg <= 25'(ey) - 25'(sy);

            hz_reg[0] <= (ddy_reg == '0);
            hv_reg[0] <= ddx_reg[24] ? 16'sd16384 : 16'sd0;
            if (ddx_reg[24])
            begin
                x_reg[0] <= -x0;
                y_reg[0] <= -y0;
                z_reg[0] <= ddy_reg[24] ? -TURN_HALF : TURN_HALF;
            end
            else
            begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + cordic_angle(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - cordic_angle(i);
                end
                hz_reg[i+1] <= hz_reg[i];
                hv_reg[i+1] <= hv_reg[i];
            end
        end
    end

    assign zr = (z_reg[CORDIC_STEPS] + 22'sd16) >>> 5;
    assign q  = zr[16:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (hz_reg[CORDIC_STEPS])
                shade_reg <= hv_reg[CORDIC_STEPS];
            else if (q > SHADE_LIMIT)
                shade_reg <= SHADE_LIMIT[15:0];
            else if (q < -SHADE_LIMIT)
                shade_reg <= 16'(-SHADE_LIMIT);
            else
                shade_reg <= q[15:0];
        end
    end

    if (PAD > 0)
    begin : g_pad
        logic signed [15:0] pad_reg [0:PAD-1];
        always_ff @(posedge clk)
        begin
            if (en)
                pad_reg[0] <= shade_reg;
        end
        for (genvar k = 1; k < PAD; k++)
        begin : g_tap
            always_ff @(posedge clk)
            begin
                if (en)
                    pad_reg[k] <= pad_reg[k-1];
            end
        end
        assign shade = pad_reg[PAD-1];
    end
    else
    begin : g_nopad
        assign shade = shade_reg;
    end

endmodule
`default_nettype wire

/* design/wall_segment_perspective_projection_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wall_segment_perspective_projection_core
// Projects one wall segment per request to screen columns, rows and shade.
// ----------------------------------------------------------------------------
// Usage:
//   wall channel (wall_valid/wall_stall/wall) carries one wall request;
//   proj channel (proj_valid/proj_stall/proj) returns one projection each.
//   APB port sets camera position, yaw cosine/sine and eye height; write
//   only while no request is in flight.
//   Throughput: one request per cycle while wall_stall is low. Two endpoint
//   lanes run side by side, each with three pipelined dividers (one quotient
//   bit per stage) of NUM_W = 43 + clog2(PROJECTION_SCALE + 1) bits
//   (51 at defaults).
//   Stalls: the pipeline moves as a whole; an output register plus a skid
//   register absorb one extra result, and wall_stall rises only once the
//   skid register is full.
//   Reset: clears valids and loads the register reset values; no
//   results are pending afterward.
// ----------------------------------------------------------------------------
module wall_segment_perspective_projection_core #(
    parameter int SCREEN_WIDTH     = 640,
    parameter int SCREEN_HEIGHT    = 480,
    parameter int PROJECTION_SCALE = 200
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wall_valid,
    output logic                wall_stall,
    input  wire wsp_pkg::wall_t wall,
    output logic                proj_valid,
    input  wire logic           proj_stall,
    output wsp_pkg::proj_t      proj,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wsp_pkg::*;

    localparam int PS_W   = $clog2(PROJECTION_SCALE + 1);
    localparam int NUM_W  = 43 + PS_W;
    localparam int QW     = NUM_W + 2;
    localparam int CW     = QW + 1;
    localparam int LAT    = NUM_W + 6;
    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;

    logic signed [23:0] cam_x_reg, cam_y_reg, eye_reg;
    logic signed [15:0] cos_reg, sin_reg;

    logic        en;
    logic        vld_reg [0:LAT-1];
    logic        proj_valid_reg, skid_full_reg;
    proj_t       proj_reg, skid_reg, merged;
    logic        cfg_wr;

    logic signed [QW-1:0] col_q [0:1];
    logic signed [QW-1:0] flr_q [0:1];
    logic signed [QW-1:0] cei_q [0:1];
    logic signed [15:0]   shade_w;
    logic signed [CW-1:0] c0, c1, f0, f1, h0, h1;
    logic                 swap;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cos_reg   <= YAW_COSINE_RESET;
            sin_reg   <= '0;
            eye_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                CFG_CAMERA_X:   cam_x_reg <= pwdata[23:0];
                CFG_CAMERA_Y:   cam_y_reg <= pwdata[23:0];
                CFG_YAW_COSINE: cos_reg   <= pwdata[15:0];
                CFG_YAW_SINE:   sin_reg   <= pwdata[15:0];
                CFG_EYE_HEIGHT: eye_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            CFG_CAMERA_X:   prdata = 32'(cam_x_reg);
            CFG_CAMERA_Y:   prdata = 32'(cam_y_reg);
            CFG_YAW_COSINE: prdata = 32'(cos_reg);
            CFG_YAW_SINE:   prdata = 32'(sin_reg);
            CFG_EYE_HEIGHT: prdata = 32'(eye_reg);
            default:        prdata = '0;
        endcase
    end

    // pipeline control
    assign en         = !skid_full_reg;
    assign wall_stall = skid_full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= wall_valid;
    end

    for (genvar k = 1; k < LAT; k++)
    begin : g_vld
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // endpoint lanes
    wsp_lane #(.PROJECTION_SCALE(PROJECTION_SCALE), .NUM_W(NUM_W)) u_lane0 (
        .clk (clk), .en (en), .px (wall.start_x), .py (wall.start_y),
        .cam_x (cam_x_reg), .cam_y (cam_y_reg), .cosv (cos_reg), .sinv (sin_reg),
        .fz (wall.floor_z), .cs (wall.ceiling_span), .eye (eye_reg),
        .col_q (col_q[0]), .floor_q (flr_q[0]), .ceil_q (cei_q[0])
    );

    wsp_lane #(.PROJECTION_SCALE(PROJECTION_SCALE), .NUM_W(NUM_W)) u_lane1 (
        .clk (clk), .en (en), .px (wall.end_x), .py (wall.end_y),
        .cam_x (cam_x_reg), .cam_y (cam_y_reg), .cosv (cos_reg), .sinv (sin_reg),
        .fz (wall.floor_z), .cs (wall.ceiling_span), .eye (eye_reg),
        .col_q (col_q[1]), .floor_q (flr_q[1]), .ceil_q (cei_q[1])
    );

    wsp_cordic #(.LAT(LAT)) u_cordic (
        .clk (clk), .en (en),
        .sx (wall.start_x), .sy (wall.start_y), .ex (wall.end_x), .ey (wall.end_y),
        .shade (shade_w)
    );

    // merge: order left to right
    assign c0   = CW'(col_q[0]) + CW'(HALF_W);
    assign c1   = CW'(col_q[1]) + CW'(HALF_W);
    assign f0   = CW'(flr_q[0]) + CW'(HALF_H);
    assign f1   = CW'(flr_q[1]) + CW'(HALF_H);
    assign h0   = CW'(cei_q[0]) + CW'(HALF_H);
    assign h1   = CW'(cei_q[1]) + CW'(HALF_H);
    assign swap = c0 > c1;

    always_comb
    begin
        merged.left_column       = sat16(64'(swap ? c1 : c0));
        merged.right_column      = sat16(64'(swap ? c0 : c1));
        merged.left_floor_row    = sat16(64'(swap ? f1 : f0));
        merged.right_floor_row   = sat16(64'(swap ? f0 : f1));
        merged.left_ceiling_row  = sat16(64'(swap ? h1 : h0));
        merged.right_ceiling_row = sat16(64'(swap ? h0 : h1));
        merged.skip              = (c0 == c1);
        merged.shade             = shade_w;
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_valid_reg <= 1'b0;
            skid_full_reg  <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (!proj_stall)
                skid_full_reg <= 1'b0;
        end
        else if (vld_reg[LAT-1])
        begin
            if (!proj_valid_reg || !proj_stall)
                proj_valid_reg <= 1'b1;
            else
                skid_full_reg <= 1'b1;
        end
        else if (!proj_stall)
        begin
            proj_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (!proj_stall)
                proj_reg <= skid_reg;
        end
        else if (vld_reg[LAT-1])
        begin
            if (!proj_valid_reg || !proj_stall)
                proj_reg <= merged;
            else
                skid_reg <= merged;
        end
    end

    assign proj_valid = proj_valid_reg;
    assign proj       = proj_reg;

`ifndef SYNTHESIS
    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> proj_valid_reg)
        else $error("skid full without output result");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(proj_valid_reg && proj_stall))
        else $error("skid filled while output free");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        proj_valid_reg |-> (proj_reg.left_column <= proj_reg.right_column))
        else $error("columns out of order");

    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (proj_valid_reg && proj_reg.skip) |->
        (proj_reg.left_column == proj_reg.right_column))
        else $error("skip with unequal columns");

    a_shade: assert property (@(posedge clk) disable iff (!rst_n)
        proj_valid_reg |-> (proj_reg.shade >= -16'sd16384 && proj_reg.shade <= 16'sd16384))
        else $error("shade out of range");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Wall projector regression
// Drives wall requests through the valid/stall channel with random gaps and
// output stalls, programs camera registers over APB between phases, compares
// every projection field by field to typed values or an in-bench projector.
// ----------------------------------------------------------------------------
module testbench;
    import wsp_pkg::*;

    localparam int SCR_W    = 640;
    localparam int SCR_H    = 480;
    localparam int PSCALE   = 200;
    localparam int SETTLE   = 70;
    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        wall_valid;
    logic        wall_stall;
    wall_t       wall;
    logic        proj_valid;
    logic        proj_stall;
    proj_t       proj;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wall_segment_perspective_projection_core DUT (
        .clk(clk), .rst_n(rst_n),
        .wall_valid(wall_valid), .wall_stall(wall_stall), .wall(wall),
        .proj_valid(proj_valid), .proj_stall(proj_stall), .proj(proj),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        wall_t w;
        bit    typed;
        proj_t p;
    } wall_row_t;

    longint cam_x, cam_y, cos_q, sin_q, eye_z;
    proj_t  proj_expected[$];
    bit     failed;
    bit     stall_busy;
    int     idle_cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q--;
        return q;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] wall_shade(longint dx, longint dy);
        longint x, y, z, nx, ny, q;
        longint angles[16];
        angles = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                   652, 326, 163, 81, 41, 20, 10, 5};
        z = 0;
        if (dy == 0)
            return (dx < 0) ? 16'sd16384 : 16'sd0;
        x = dx <<< 20;
        y = dy <<< 20;
        if (x < 0)
        begin
            z = (y >= 0) ? 524288 : -524288;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += angles[i];
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= angles[i];
            end
            x = nx;
            y = ny;
        end
        q = (z + 16) >>> 5;
        if (q > 16384)
            q = 16384;
        if (q < -16384)
            q = -16384;
        return q[15:0];
    endfunction

    function automatic proj_t project_wall(wall_t w);
        longint sx, sy, ex, ey, fz, cs;
        longint rx0, ry0, rx1, ry1, c0, c1, dl, dr, t, hf, hc;
        proj_t  p;
        sx = w.start_x; sy = w.start_y; ex = w.end_x; ey = w.end_y;
        fz = w.floor_z; cs = w.ceiling_span;
        rx0 = (sx - cam_x) * cos_q - (sy - cam_y) * sin_q;
        ry0 = (sx - cam_x) * sin_q + (sy - cam_y) * cos_q;
        rx1 = (ex - cam_x) * cos_q - (ey - cam_y) * sin_q;
        ry1 = (ex - cam_x) * sin_q + (ey - cam_y) * cos_q;
        if (ry0 == 0)
            ry0 = 1;
        if (ry1 == 0)
            ry1 = 1;
        c0 = floor_div(rx0 * PSCALE, ry0) + SCR_W / 2;
        c1 = floor_div(rx1 * PSCALE, ry1) + SCR_W / 2;
        dl = ry0;
        dr = ry1;
        if (c0 > c1)
        begin
            t = c0; c0 = c1; c1 = t;
            t = dl; dl = dr; dr = t;
        end
        hf = (fz - eye_z) * PSCALE * 16384;
        hc = (fz + cs - eye_z) * PSCALE * 16384;
        p.left_column       = clip16(c0);
        p.right_column      = clip16(c1);
        p.left_floor_row    = clip16(floor_div(hf, dl) + SCR_H / 2);
        p.right_floor_row   = clip16(floor_div(hf, dr) + SCR_H / 2);
        p.left_ceiling_row  = clip16(floor_div(hc, dl) + SCR_H / 2);
        p.right_ceiling_row = clip16(floor_div(hc, dr) + SCR_H / 2);
        p.skip              = (c0 == c1);
        p.shade             = wall_shade(ex - sx, ey - sy);
        return p;
    endfunction

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
            failed = 1;
        end
    endtask

    always @(posedge clk)
    begin
        proj_t e;
        if (rst_n && proj_valid && !proj_stall)
        begin
            if (proj_expected.size() == 0)
            begin
                $display("%0t: unexpected projection, expected none, actual %p", $time, proj);
                failed = 1;
            end
            else
            begin
                e = proj_expected.pop_front();
                check_field("left_column", e.left_column, proj.left_column);
                check_field("right_column", e.right_column, proj.right_column);
                check_field("left_floor_row", e.left_floor_row, proj.left_floor_row);
                check_field("right_floor_row", e.right_floor_row, proj.right_floor_row);
                check_field("left_ceiling_row", e.left_ceiling_row,
                            proj.left_ceiling_row);
                check_field("right_ceiling_row", e.right_ceiling_row,
                            proj.right_ceiling_row);
                check_field("skip", e.skip, proj.skip);
                check_field("shade", e.shade, proj.shade);
            end
        end
    end

    // output backpressure: alternating busy and quiet stretches
    always @(posedge clk)
    begin
        int r;
        if ($urandom_range(0, 299) == 0)
            stall_busy <= ~stall_busy;
        r = $urandom_range(0, 99);
        if (!stall_busy)
            proj_stall <= 1'b0;
        else if (proj_stall)
            proj_stall <= ($urandom_range(0, 99) < 70);
        else
            proj_stall <= (r < 25);
    end

    always @(posedge clk)
    begin
        if ((wall_valid && !wall_stall) || (proj_valid && !proj_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG)
        begin
            $display("wall_segment_perspective_projection_core regression: fail");
            $finish;
        end
    end

    // setup then access cycle; the caller releases psel after the last write
    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            CFG_CAMERA_X:   cam_x = $signed(v[23:0]);
            CFG_CAMERA_Y:   cam_y = $signed(v[23:0]);
            CFG_YAW_COSINE: cos_q = $signed(v[15:0]);
            CFG_YAW_SINE:   sin_q = $signed(v[15:0]);
            CFG_EYE_HEIGHT: eye_z = $signed(v[23:0]);
            default: ;
        endcase
    endtask

    task automatic set_camera(int x, int y, int c, int s, int h);
        reg_write(CFG_CAMERA_X, x);
        reg_write(CFG_CAMERA_Y, y);
        reg_write(CFG_YAW_COSINE, c);
        reg_write(CFG_YAW_SINE, s);
        reg_write(CFG_EYE_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int request_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    task automatic send_wall(wall_t w, bit typed, proj_t p);
        int gap;
        wall       <= w;
        wall_valid <= 1'b1;
        do
            @(posedge clk);
        while (wall_stall);
        proj_expected.push_back(typed ? p : project_wall(w));
        gap = request_gap();
        if (gap > 0)
        begin
            wall_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] coord24();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 40000) - 20000;
        if (r < 85)
            return $urandom();
        case ($urandom_range(0, 3))
            0:       return 24'h7fffff;
            1:       return 24'h800000;
            2:       return 24'h000000;
            default: return 24'hffffff;
        endcase
    endfunction

    function automatic wall_t random_wall();
        wall_t w;
        w.start_x      = coord24();
        w.start_y      = coord24();
        w.end_x        = ($urandom_range(0, 9) == 0) ? w.start_x : coord24();
        w.end_y        = ($urandom_range(0, 9) == 0) ? w.start_y : coord24();
        w.floor_z      = coord24();
        w.ceiling_span = coord24();
        return w;
    endfunction

    task automatic drain();
        wait (proj_expected.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    wall_row_t directed[$];
    proj_t     none;

    initial
    begin
        int cs, sn;
        rst_n      = 1'b0;
        wall_valid = 1'b0;
        wall       = '0;
        proj_stall = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        failed     = 1'b0;
        stall_busy = 1'b0;
        idle_cycles = 0;
        none       = '0;
        cam_x = 0; cam_y = 0; cos_q = YAW_COSINE_RESET; sin_q = 0; eye_z = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset camera: values readable by hand
        directed.push_back('{'0, 1'b1, '{320, 320, 240, 240, 240, 240, 1'b1, 16'sd0}});
        directed.push_back('{'{24'sd0, 24'sd256, 24'sd0, 24'sd256, 24'sd0, 24'sd0},
                             1'b1, '{320, 320, 240, 240, 240, 240, 1'b1, 16'sd0}});
        directed.push_back('{'{24'sd256, 24'sd256, -24'sd256, 24'sd256, 24'sd0, 24'sd0},
                             1'b1, '{120, 520, 240, 240, 240, 240, 1'b0, 16'sd16384}});
        directed.push_back('{'{-24'sd256, 24'sd256, 24'sd256, 24'sd256, 24'sd512,
                               24'sd256}, 1'b0, none});
        directed.push_back('{'{24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000,
                               24'sh7fffff, 24'sh7fffff}, 1'b0, none});
        directed.push_back('{'{24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff,
                               24'sh800000, 24'sh800000}, 1'b0, none});
        directed.push_back('{'{24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000,
                               24'sh800000, 24'sh7fffff}, 1'b0, none});
        directed.push_back('{'{24'sd100, -24'sd300, -24'sd500, 24'sd700, -24'sd9,
                               24'sd1000}, 1'b0, none});
        directed.push_back('{'{24'sd0, 24'sd0, -24'sd256, -24'sd1, 24'sd0, 24'sd0},
                             1'b0, none});
        directed.push_back('{'{24'sd0, 24'sd0, -24'sd256, 24'sd1, 24'sd0, 24'sd0},
                             1'b0, none});
        directed.push_back('{'{-24'sd1, 24'sd0, 24'sd1, 24'sd0, 24'sd0, 24'sd0},
                             1'b0, none});
        directed.push_back('{'{24'sd5, -24'sd2560, 24'sd5, 24'sd2560, 24'sd100, 24'sd100},
                             1'b0, none});
        foreach (directed[i])
            send_wall(directed[i].w, directed[i].typed, directed[i].p);

        for (int ph = 0; ph < 7; ph++)
        begin
            wall_valid <= 1'b0;
            drain();
            case (ph)
                0: set_camera(0, 0, 16384, 0, 0);
                1: set_camera(24'h7fffff, 24'h800000, -16384, 0, 24'h7fffff);
                2: set_camera(24'h800000, 24'h7fffff, 0, 16384, 24'h800000);
                3: set_camera(0, 0, 0, -16384, 512);
                4: set_camera(-1000, 2000, 11585, 11585, -300);
                5: set_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                default:
                begin
                    cs = $urandom_range(0, 32768) - 16384;
                    sn = $urandom_range(0, 32768) - 16384;
                    set_camera($urandom_range(0, 4000) - 2000,
                               $urandom_range(0, 4000) - 2000, cs, sn,
                               $urandom_range(0, 2000) - 1000);
                end
            endcase
            if (ph == 0)
            begin
                // more extremes, with the reset camera values now written over APB
                send_wall('{24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff,
                            24'sh7fffff, 24'sh800000}, 1'b0, none);
                send_wall('1, 1'b0, none);
            end
            repeat (135) send_wall(random_wall(), 1'b0, none);
        end

        wall_valid <= 1'b0;
        drain();
        if (!failed)
            $display("wall_segment_perspective_projection_core regression: pass");
        else
            $display("wall_segment_perspective_projection_core regression: fail");
        $finish;
    end
endmodule
